// ===== hdl/energy_tank_passivity_filter_macros.svh =====
// Assertion macros for the energy tank passivity filter
`ifndef ENERGY_TANK_PASSIVITY_FILTER_MACROS_SVH
`define ENERGY_TANK_PASSIVITY_FILTER_MACROS_SVH
// implication checked on every clock edge outside reset
`define ETPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ETPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/etpf_pkg.sv =====
// Shared types and constants for the energy tank passivity filter
`default_nettype none
package etpf_pkg;
    typedef enum logic [2:0] {
        REG_TRACKING_GAIN = 3'd0,
        REG_DAMPING_GAIN  = 3'd1,
        REG_STEP_TIME     = 3'd2,
        REG_ENERGY_MAX    = 3'd3,
        REG_ENERGY_MIN    = 3'd4,
        REG_LEVEL_MAX     = 3'd5,
        REG_LEVEL_MIN     = 3'd6
    } reg_index_t;

    // datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // latch inputs, first tick load, error terms
        OP_MUL_GEX,   // t = gain*ex
        OP_MUL_GEY,
        OP_PVX,       // pv = motion ? sat(t+dv) : mv
        OP_PVY,
        OP_MUL_PXS,   // ref += pv*dt
        OP_MUL_PYS,
        OP_RXY,       // r = pv - mv, commit new reference
        OP_MUL_RXRX,
        OP_MUL_RYRY,  // sq
        OP_MUL_DSQ,   // damp
        OP_MUL_RXFX,
        OP_MUL_RYFY,  // fp, num
        OP_DIV_START,
        OP_MUL_DTZ,   // z
        OP_MUL_ZZ,    // clamp, energy
        OP_MUL_GEX2,
        OP_MUL_GEY2,
        OP_CXY,
        OP_MUL_CXFX,
        OP_MUL_CYFY,  // flags, commit
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
    } ctrl_status_t;
endpackage
`default_nettype wire

// ===== hdl/etpf_ctrl.sv =====
// Controller sequencing the datapath steps of one transaction
`default_nettype none
module etpf_ctrl
    import etpf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);
`include "energy_tank_passivity_filter_macros.svh"
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    op_next    = OP_MUL_GEX;
                end
            end
            ST_RUN:
            begin
                if (op_reg == OP_DIV_START)
                begin
                    state_next = ST_DIV;
                    op_next    = OP_NONE;
                end
                else if (op_reg == OP_MUL_CYFY)
                begin
                    state_next = ST_OUT;
                    op_next    = OP_NONE;
                end
                else
                begin
                    op_next = op_t'(op_reg + 5'd1);
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RUN;
                    op_next    = OP_MUL_DTZ;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        // inputs are latched on the accepting edge itself
        cmd.op    = (state_reg == ST_RUN) ? op_reg
                  : ((state_reg == ST_IDLE && in_valid) ? OP_LOAD : OP_NONE);
    end

    `ETPF_ASSERT_IMP(a_excl, in_ready, !out_valid)
    `ETPF_ASSERT_NEXT(a_acc, in_valid && in_ready, state_reg == ST_RUN && op_reg == OP_MUL_GEX)
    `ETPF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

// ===== hdl/etpf_datapath.sv =====
// Datapath: shared multiplier, restoring divider, tank and reference registers
`default_nettype none
module etpf_datapath
    import etpf_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctrl_cmd_t           cmd,
    output ctrl_status_t             status,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_idx,
    input  wire logic [30:0]         cfg_data,
    input  wire logic                first_tick,
    input  wire logic signed [31:0]  desired_pos_x,
    input  wire logic signed [31:0]  desired_pos_y,
    input  wire logic signed [31:0]  desired_vel_x,
    input  wire logic signed [31:0]  desired_vel_y,
    input  wire logic signed [31:0]  measured_vel_x,
    input  wire logic signed [31:0]  measured_vel_y,
    input  wire logic signed [31:0]  force_x,
    input  wire logic signed [31:0]  force_y,
    output logic signed [31:0]       passive_pos_x,
    output logic signed [31:0]       passive_pos_y,
    output logic signed [31:0]       passive_vel_x,
    output logic signed [31:0]       passive_vel_y,
    output logic [30:0]              level_out,
    output logic [30:0]              energy_out,
    output logic                     advance
);
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;
    localparam int QW = 32 + FRAC_BITS + 1;   // divide numerator width (magnitude)

    function automatic logic signed [31:0] sat(input logic signed [63:0] x);
        if (x > SMAX)
            return 32'sh7FFFFFFF;
        else if (x < SMIN)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    logic [30:0] trk_reg, dmp_reg, dt_reg, emax_reg, emin_reg, lmax_reg, lmin_reg;
    logic signed [31:0] rpx_reg, rpy_reg;
    logic [30:0] lvl_reg;
    logic motion_reg, refill_reg, drain_reg;

    logic signed [31:0] dpx_reg, dpy_reg, dvx_reg, dvy_reg, mvx_reg, mvy_reg, fx_reg, fy_reg;
    logic signed [31:0] ex_reg, ey_reg, t_reg, pvx_reg, pvy_reg, rx_reg, ry_reg;
    logic signed [31:0] acc_reg, num_reg, fp_reg, zdot_reg;
    logic signed [33:0] z_reg;
    logic [30:0] znew_reg, enew_reg;
    logic signed [31:0] nrpx_reg, nrpy_reg;
    logic [30:0] olvl_reg, oeng_reg;
    logic oadv_reg;
    logic signed [31:0] fpd_reg;

    // multiplier operand select
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [63:0] prod_sh;
    logic signed [31:0] mq;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_MUL_GEX, OP_MUL_GEX2: begin ma = {3'b0, trk_reg}; mb = 34'(ex_reg); end
            OP_MUL_GEY, OP_MUL_GEY2: begin ma = {3'b0, trk_reg}; mb = 34'(ey_reg); end
            OP_MUL_PXS:  begin ma = 34'(pvx_reg); mb = {3'b0, dt_reg}; end
            OP_MUL_PYS:  begin ma = 34'(pvy_reg); mb = {3'b0, dt_reg}; end
            OP_MUL_RXRX: begin ma = 34'(rx_reg); mb = 34'(rx_reg); end
            OP_MUL_RYRY: begin ma = 34'(ry_reg); mb = 34'(ry_reg); end
            OP_MUL_DSQ:  begin ma = {3'b0, dmp_reg}; mb = 34'(acc_reg); end
            OP_MUL_RXFX: begin ma = 34'(rx_reg); mb = 34'(fx_reg); end
            OP_MUL_RYFY: begin ma = 34'(ry_reg); mb = 34'(fy_reg); end
            OP_MUL_DTZ:  begin ma = {3'b0, dt_reg}; mb = 34'(zdot_reg); end
            OP_MUL_ZZ:   begin ma = z_reg; mb = z_reg; end
            OP_MUL_CXFX: begin ma = 34'(rx_reg); mb = 34'(fx_reg); end
            OP_MUL_CYFY: begin ma = 34'(ry_reg); mb = 34'(fy_reg); end
            default: ;
        endcase
        prod    = ma * mb;
        prod_sh = 64'(prod >>> FRAC_BITS);
        mq      = sat(prod_sh);
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    logic [QW-1:0] dq_reg;
    logic [31:0]   dr_reg, dd_reg;
    logic [6:0]    dcnt_reg;
    logic          dneg_reg, dbusy_reg;
    logic [32:0]   dtrial;
    logic [QW-1:0] nmag;
    logic [31:0]   dvs;
    logic signed [QW:0] qsig;

    assign status.div_busy = dbusy_reg;
    assign dtrial = {dr_reg, dq_reg[QW-1]} - {1'b0, dd_reg};
    assign nmag = QW'(num_reg[31] ? -(64'(num_reg)) : 64'(num_reg)) << FRAC_BITS;
    assign dvs = (lvl_reg == '0) ? 32'd1 : {1'b0, lvl_reg};
    assign qsig = dneg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

    logic signed [31:0] sumx, sumy;
    logic signed [33:0] zsum;
    logic signed [31:0] exn, eyn, cxn, cyn, dotv;
    logic motion_n, refill_n;

    always_comb
    begin
        zsum = 34'(lvl_reg) + 34'(mq);
        sumx = sat(64'(nrpx_reg));
        sumy = sat(64'(nrpy_reg));
        exn  = sat(64'(dpx_reg) - 64'(rpx_reg));
        eyn  = sat(64'(dpy_reg) - 64'(rpy_reg));
        cxn  = sat(64'(sat(64'(t_reg) + 64'(dvx_reg))) - 64'(mvx_reg));
        cyn  = sat(64'(acc_reg) - 64'(mvy_reg));
        dotv = sat(64'(fp_reg) + 64'(mq));
        refill_n = {1'b0, enew_reg} < {1'b0, emax_reg};
        motion_n = !((enew_reg <= emin_reg) && !dotv[31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg    <= 31'd838860800;
            dmp_reg    <= 31'd838860800;
            dt_reg     <= 31'd16777;
            emax_reg   <= 31'd167772;
            emin_reg   <= 31'd8389;
            lmax_reg   <= 31'd2372646;
            lmin_reg   <= 31'd530543;
            rpx_reg    <= '0;
            rpy_reg    <= '0;
            lvl_reg    <= 31'd2372646;
            motion_reg <= 1'b1;
            refill_reg <= 1'b1;
            drain_reg  <= 1'b1;
            dbusy_reg  <= 1'b0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_TRACKING_GAIN: trk_reg <= cfg_data;
                    REG_DAMPING_GAIN:  dmp_reg <= cfg_data;
                    REG_STEP_TIME:     dt_reg  <= cfg_data;
                    REG_ENERGY_MAX:
                    begin
                        emax_reg <= cfg_data;
                    end
                    REG_ENERGY_MIN:    emin_reg <= cfg_data;
                    REG_LEVEL_MAX:     lmax_reg <= cfg_data;
                    REG_LEVEL_MIN:     lmin_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_LOAD && first_tick)
            begin
                rpx_reg <= desired_pos_x;
                rpy_reg <= desired_pos_y;
            end
            if (cmd.op == OP_RXY)
            begin
                rpx_reg <= sumx;
                rpy_reg <= sumy;
            end
            if (cmd.op == OP_DIV_START)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 7'(QW);
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1)
                    dbusy_reg <= 1'b0;
            end
            // clamped level is committed in the step after the clamp
            if (cmd.op == OP_MUL_GEX2)
                lvl_reg <= znew_reg;
            if (cmd.op == OP_MUL_CYFY)
            begin
                motion_reg <= motion_n;
                refill_reg <= refill_n;
                drain_reg  <= fpd_reg[31] ? refill_n : 1'b1;
            end
        end
    end

    // first-tick values not yet committed when the error terms are formed
    logic signed [31:0] rpx_use, rpy_use;
    assign rpx_use = first_tick ? desired_pos_x : rpx_reg;
    assign rpy_use = first_tick ? desired_pos_y : rpy_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                dpx_reg <= desired_pos_x;  dpy_reg <= desired_pos_y;
                dvx_reg <= desired_vel_x;  dvy_reg <= desired_vel_y;
                mvx_reg <= measured_vel_x; mvy_reg <= measured_vel_y;
                fx_reg  <= force_x;        fy_reg  <= force_y;
                ex_reg  <= sat(64'(desired_pos_x) - 64'(rpx_use));
                ey_reg  <= sat(64'(desired_pos_y) - 64'(rpy_use));
            end
            OP_MUL_GEX: t_reg <= mq;
            OP_MUL_GEY: acc_reg <= mq;
            OP_PVX:
            begin
                pvx_reg <= motion_reg ? sat(64'(t_reg) + 64'(dvx_reg)) : mvx_reg;
            end
            OP_PVY:
            begin
                pvy_reg <= motion_reg ? sat(64'(acc_reg) + 64'(dvy_reg)) : mvy_reg;
            end
            OP_MUL_PXS: nrpx_reg <= 32'(sat(64'(rpx_reg) + 64'(mq)));
            OP_MUL_PYS: nrpy_reg <= 32'(sat(64'(rpy_reg) + 64'(mq)));
            OP_RXY:
            begin
                rx_reg <= sat(64'(pvx_reg) - 64'(mvx_reg));
                ry_reg <= sat(64'(pvy_reg) - 64'(mvy_reg));
            end
            OP_MUL_RXRX: acc_reg <= mq;
            OP_MUL_RYRY: acc_reg <= sat(64'(acc_reg) + 64'(mq));
            OP_MUL_DSQ:  acc_reg <= mq;
            OP_MUL_RXFX: fp_reg <= mq;
            OP_MUL_RYFY:
            begin
                fp_reg  <= sat(64'(fp_reg) + 64'(mq));
                num_reg <= sat((refill_reg ? 64'(acc_reg) : 64'sd0)
                               - (drain_reg ? 64'(sat(64'(fp_reg) + 64'(mq))) : 64'sd0));
            end
            OP_DIV_START:
            begin
                dq_reg   <= nmag;
                dr_reg   <= '0;
                dd_reg   <= dvs;
                dneg_reg <= num_reg[31];
            end
            OP_MUL_DTZ:
            begin
                z_reg <= zsum;
                // restore exit of divider done before this step
            end
            OP_MUL_ZZ:
            begin
                if (z_reg < $signed({3'b0, lmin_reg}))
                begin
                    znew_reg <= lmin_reg;
                    enew_reg <= emin_reg;
                end
                else if (z_reg > $signed({3'b0, lmax_reg}))
                begin
                    znew_reg <= lmax_reg;
                    enew_reg <= emax_reg;
                end
                else
                begin
                    znew_reg <= z_reg[30:0];
                    enew_reg <= (64'(prod >>> (FRAC_BITS + 1)) > 64'sd2147483647)
                                ? 31'h7FFFFFFF : 31'(prod >>> (FRAC_BITS + 1));
                end
                ex_reg <= sat(64'(dpx_reg) - 64'(rpx_reg));
                ey_reg <= sat(64'(dpy_reg) - 64'(rpy_reg));
            end
            OP_MUL_GEX2: t_reg <= mq;
            OP_MUL_GEY2:
            begin
                acc_reg <= sat(64'(mq) + 64'(dvy_reg));
                rx_reg  <= cxn;
            end
            OP_CXY: ry_reg <= cyn;
            OP_MUL_CXFX: fp_reg <= mq;
            OP_MUL_CYFY:
            begin
                olvl_reg <= lvl_reg;
                oeng_reg <= enew_reg;
                oadv_reg <= motion_n;
                fp_reg   <= fp_reg;
            end
            default: ;
        endcase
        if (dbusy_reg)
        begin
            if (!dtrial[32])
            begin
                dr_reg <= dtrial[31:0];
                dq_reg <= {dq_reg[QW-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[30:0], dq_reg[QW-1]};
                dq_reg <= {dq_reg[QW-2:0], 1'b0};
            end
        end
        if (!dbusy_reg && cmd.op == OP_NONE)
            zdot_reg <= sat(64'(qsig));
    end

    // dot for flag update uses old fp: keep the damping-path fp separately
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL_RYFY)
            fpd_reg <= sat(64'(fp_reg) + 64'(mq));
    end

    assign passive_pos_x = rpx_reg;
    assign passive_pos_y = rpy_reg;
    assign passive_vel_x = pvx_reg;
    assign passive_vel_y = pvy_reg;
    assign level_out     = olvl_reg;
    assign energy_out    = oeng_reg;
    assign advance       = oadv_reg;
endmodule
`default_nettype wire

// ===== hdl/energy_tank_passivity_filter.sv =====
// Energy tank passivity filter: top level
//
// Input channel in_valid/in_ready carries one control tick; output channel
// out_valid/out_ready returns one result per tick (passive position and
// velocity, tank level and energy, advance flag).
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while no transaction is in flight.
// Each accepted tick steps through a sequencer driving one shared 34x34
// multiplier and a restoring divider that retires one quotient bit per
// cycle; out_valid rises once the last step has committed the result.
// One transaction at a time; in_ready is low from acceptance until the result
// is taken. A stalled receiver holds the result and the block.
// Reset loads the default registers, clears the reference position, fills
// the tank level to level_max and sets motion, refill and drain.
`default_nettype none
module energy_tank_passivity_filter
    import etpf_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               first_tick,
    input  wire logic signed [31:0] desired_pos_x,
    input  wire logic signed [31:0] desired_pos_y,
    input  wire logic signed [31:0] desired_vel_x,
    input  wire logic signed [31:0] desired_vel_y,
    input  wire logic signed [31:0] measured_vel_x,
    input  wire logic signed [31:0] measured_vel_y,
    input  wire logic signed [31:0] force_x,
    input  wire logic signed [31:0] force_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      passive_pos_x,
    output logic signed [31:0]      passive_pos_y,
    output logic signed [31:0]      passive_vel_x,
    output logic signed [31:0]      passive_vel_y,
    output logic [30:0]             level_out,
    output logic [30:0]             energy_out,
    output logic                    advance,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_data
);
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    etpf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
    );

    etpf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .first_tick(first_tick),
        .desired_pos_x(desired_pos_x), .desired_pos_y(desired_pos_y),
        .desired_vel_x(desired_vel_x), .desired_vel_y(desired_vel_y),
        .measured_vel_x(measured_vel_x), .measured_vel_y(measured_vel_y),
        .force_x(force_x), .force_y(force_y),
        .passive_pos_x(passive_pos_x), .passive_pos_y(passive_pos_y),
        .passive_vel_x(passive_vel_x), .passive_vel_y(passive_vel_y),
        .level_out(level_out), .energy_out(energy_out), .advance(advance)
    );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the energy tank passivity filter
`default_nettype none
module tb_top
    import etpf_pkg::*;
();

    localparam int FRAC = 24;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh01000000;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        bit                 first;
        logic signed [31:0] dpx, dpy, dvx, dvy, mvx, mvy, fx, fy;
    } tick_t;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [30:0]        lvl, nrg;
        logic               adv;
    } tank_out_t;

    logic clk, rst_n;
    logic in_valid, in_ready, first_tick;
    logic signed [31:0] desired_pos_x, desired_pos_y, desired_vel_x, desired_vel_y;
    logic signed [31:0] measured_vel_x, measured_vel_y, force_x, force_y;
    logic out_valid, out_ready;
    logic signed [31:0] passive_pos_x, passive_pos_y, passive_vel_x, passive_vel_y;
    logic [30:0] level_out, energy_out;
    logic advance;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [30:0] cfg_data;

    energy_tank_passivity_filter dut (.*);

    // predictor state
    longint gain_r, damp_r, dt_r, emax_r, emin_r, lmax_r, lmin_r;
    longint pos_x, pos_y, tank_lvl, tank_nrg;
    bit motion, refill, drain;

    tank_out_t pending[$];
    int errors;
    int send_idle_pct, recv_stall_pct;
    int hold_cycles;

    function automatic longint sat32(longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return sat32(p >>> FRAC);
    endfunction

    function automatic longint qdot(longint ax, longint ay, longint bx, longint by);
        return sat32(qmul(ax, bx) + qmul(ay, by));
    endfunction

    task automatic tank_reset();
        gain_r = 838860800; damp_r = 838860800; dt_r = 16777;
        emax_r = 167772; emin_r = 8389; lmax_r = 2372646; lmin_r = 530543;
        pos_x = 0; pos_y = 0;
        tank_lvl = lmax_r; tank_nrg = emax_r;
        motion = 1; refill = 1; drain = 1;
    endtask

    function automatic tank_out_t tank_predict(tick_t t);
        longint dpx, dpy, dvx, dvy, mvx, mvy, fx, fy;
        longint ex, ey, pvx, pvy, rx, ry, sq, dmp, fp, num, dv, zdot, z, e;
        longint cx, cy, cdot;
        tank_out_t r;
        dpx = t.dpx; dpy = t.dpy; dvx = t.dvx; dvy = t.dvy;
        mvx = t.mvx; mvy = t.mvy; fx = t.fx; fy = t.fy;
        if (t.first) begin
            pos_x = dpx;
            pos_y = dpy;
        end
        if (motion) begin
            ex = sat32(dpx - pos_x);
            ey = sat32(dpy - pos_y);
            pvx = sat32(qmul(gain_r, ex) + dvx);
            pvy = sat32(qmul(gain_r, ey) + dvy);
        end else begin
            pvx = mvx;
            pvy = mvy;
        end
        pos_x = sat32(pos_x + qmul(pvx, dt_r));
        pos_y = sat32(pos_y + qmul(pvy, dt_r));
        rx = sat32(pvx - mvx);
        ry = sat32(pvy - mvy);
        sq = qdot(rx, ry, rx, ry);
        dmp = qmul(damp_r, sq);
        fp = qdot(rx, ry, fx, fy);
        num = sat32((refill ? dmp : 0) - (drain ? fp : 0));
        dv = tank_lvl > 0 ? tank_lvl : 1;
        zdot = sat32((num * (64'sd1 << FRAC)) / dv);
        z = tank_lvl + qmul(dt_r, zdot);
        if (z < lmin_r) begin
            z = lmin_r;
            e = emin_r;
        end else if (z > lmax_r) begin
            z = lmax_r;
            e = emax_r;
        end else begin
            e = (z * z) >>> (FRAC + 1);
            if (e > S32_MAX) e = S32_MAX;
        end
        tank_lvl = z;
        tank_nrg = e;
        // flags use the error against the updated reference
        ex = sat32(dpx - pos_x);
        ey = sat32(dpy - pos_y);
        cx = sat32(sat32(qmul(gain_r, ex) + dvx) - mvx);
        cy = sat32(sat32(qmul(gain_r, ey) + dvy) - mvy);
        cdot = qdot(cx, cy, fx, fy);
        motion = !(e <= emin_r && cdot >= 0);
        refill = e < emax_r;
        drain = (fp < 0) ? refill : 1'b1;
        r.px = pos_x[31:0]; r.py = pos_y[31:0];
        r.vx = pvx[31:0]; r.vy = pvy[31:0];
        r.lvl = tank_lvl[30:0]; r.nrg = tank_nrg[30:0];
        r.adv = motion;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(15))
            0: return $urandom;
            1: case ($urandom_range(3))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 0;
                default: return -1;
            endcase
            2: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - Q_ONE;
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.first = ($urandom_range(9) == 0);
        t.dpx = rand_q(); t.dpy = rand_q(); t.dvx = rand_q(); t.dvy = rand_q();
        t.mvx = rand_q(); t.mvy = rand_q(); t.fx = rand_q(); t.fy = rand_q();
        return t;
    endfunction

    function automatic tick_t mk_tick(bit f, logic signed [31:0] p, logic signed [31:0] v,
                                      logic signed [31:0] m, logic signed [31:0] fr);
        tick_t t;
        t.first = f;
        t.dpx = p; t.dpy = -p; t.dvx = v; t.dvy = ~v;
        t.mvx = m; t.mvy = ~m; t.fx = fr; t.fy = -fr;
        return t;
    endfunction

    // clock and simulation timeout
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("[energy_tank_passivity_filter] ERROR");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        out_ready = 0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                tank_out_t e;
                e = pending.pop_front();
                check_field("passive_pos_x", e.px, passive_pos_x);
                check_field("passive_pos_y", e.py, passive_pos_y);
                check_field("passive_vel_x", e.vx, passive_vel_x);
                check_field("passive_vel_y", e.vy, passive_vel_y);
                check_field("level_out", e.lvl, level_out);
                check_field("energy_out", e.nrg, energy_out);
                check_field("advance", e.adv, advance);
            end
        end
    end

    task automatic send_tick(tick_t t);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        first_tick <= t.first;
        desired_pos_x <= t.dpx; desired_pos_y <= t.dpy;
        desired_vel_x <= t.dvx; desired_vel_y <= t.dvy;
        measured_vel_x <= t.mvx; measured_vel_y <= t.mvy;
        force_x <= t.fx; force_y <= t.fy;
        do @(posedge clk); while (!in_ready);
        pending = {pending, tank_predict(t)};
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(reg_index_t idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TRACKING_GAIN: gain_r = val;
            REG_DAMPING_GAIN:  damp_r = val;
            REG_STEP_TIME:     dt_r = val;
            REG_ENERGY_MAX:    emax_r = val;
            REG_ENERGY_MIN:    emin_r = val;
            REG_LEVEL_MAX:     lmax_r = val;
            REG_LEVEL_MIN:     lmin_r = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_tick(mk_tick(1, 0, 0, 0, 0));
        send_tick(mk_tick(0, Q_ONE, 0, 0, 0));
        send_tick(mk_tick(0, Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
        send_tick(mk_tick(0, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE));
        send_tick(mk_tick(1, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
        send_tick(mk_tick(0, Q_MIN, Q_MIN, Q_MAX, Q_MIN));
        send_tick(mk_tick(0, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
        send_tick(mk_tick(1, -1, -1, -1, -1));
        send_tick(mk_tick(0, 0, Q_MAX, 0, Q_MAX));
        // strong opposing force drains the tank toward its floor
        for (int i = 0; i < 6; i++)
            send_tick(mk_tick(0, 32'sh0010_0000, 32'sh0400_0000, 0, 32'sh7000_0000));
        send_tick(mk_tick(0, 32'sh0010_0000, 0, 32'sh0100_0000, 32'sh0100_0000));
        send_tick(mk_tick(0, 32'sh0010_0000, 0, 32'sh0100_0000, -32'sh0100_0000));
        // heavy damping refills the tank
        for (int i = 0; i < 4; i++)
            send_tick(mk_tick(0, 32'sh0080_0000, 32'sh0200_0000, -32'sh0200_0000, 0));
        send_tick(mk_tick(1, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        wait_drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_tick(rand_tick());
        wait_drain();
    endtask

    task automatic test_idle_phases();
        int idle_set[4] = '{0, 62, 0, 11};
        int stall_set[4] = '{0, 0, 62, 11};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            recv_stall_pct = stall_set[p];
            test_random(170);
        end
        send_idle_pct = 11;
        recv_stall_pct = 11;
    endtask

    task automatic test_config_sweep();
        logic [30:0] v;
        for (int s = 0; s < 6; s++) begin
            for (int i = REG_TRACKING_GAIN; i <= REG_LEVEL_MIN; i++) begin
                case (s)
                    0: v = '0;
                    1: v = '1;
                    2: v = 31'($urandom);
                    3: v = 31'($urandom_range(0, 32'h0400_0000));
                    default: v = 31'($urandom_range(0, 32'h0040_0000));
                endcase
                cfg_write(reg_index_t'(i), v);
            end
            // keep the floors close to the tank contents so the flags move
            if (s >= 4) begin
                cfg_write(REG_STEP_TIME, 31'($urandom_range(1, 32'h0010_0000)));
                cfg_write(REG_ENERGY_MIN, emax_r[30:0] >> 1);
                cfg_write(REG_LEVEL_MIN, lmax_r[30:0] >> 2);
            end
            test_random(40);
        end
        cfg_write(REG_TRACKING_GAIN, 31'd838860800);
        cfg_write(REG_DAMPING_GAIN, 31'd838860800);
        cfg_write(REG_STEP_TIME, 31'd16777);
        cfg_write(REG_ENERGY_MAX, 31'd167772);
        cfg_write(REG_ENERGY_MIN, 31'd8389);
        cfg_write(REG_LEVEL_MAX, 31'd2372646);
        cfg_write(REG_LEVEL_MIN, 31'd530543);
        test_random(20);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 8; i++) send_tick(rand_tick());
        wait_drain();
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        first_tick = 0;
        desired_pos_x = 0; desired_pos_y = 0; desired_vel_x = 0; desired_vel_y = 0;
        measured_vel_x = 0; measured_vel_y = 0; force_x = 0; force_y = 0;
        cfg_we = 0;
        cfg_index = REG_TRACKING_GAIN;
        cfg_data = 0;
        tank_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_idle_phases();
        test_backpressure();
        test_config_sweep();
        test_backpressure();

        if (errors == 0)
            $display("[energy_tank_passivity_filter] OK");
        else
            $display("[energy_tank_passivity_filter] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/etpf_pkg.sv
hdl/etpf_ctrl.sv
hdl/etpf_datapath.sv
hdl/energy_tank_passivity_filter.sv
tb/tb_top.sv
